// ----- hdl/wlcg_pkg.sv -----
// Shared types, constants and the quarter-wave cosine generator for the
// windowed linear chirp generator. No dependencies.
`timescale 1ns / 1ps

package wlcg_pkg;

   localparam int SINE_TABLE_BITS_DEF = 10;
   localparam int SAMPLE_BITS_DEF     = 16;
   localparam int COUNT_BITS_DEF      = 16;
   localparam int QUEUE_DEPTH         = 2;
   localparam int CSR_SETTLE          = 2;

   localparam logic [2:0] CSR_SAMPLE_COUNT = 3'd0;
   localparam logic [2:0] CSR_CHIRP_RATE   = 3'd1;
   localparam logic [2:0] CSR_WINDOW_MODE  = 3'd2;
   localparam logic [2:0] CSR_WINDOW_START = 3'd3;
   localparam logic [2:0] CSR_WINDOW_STEP  = 3'd4;

   localparam logic [1:0] WIN_NONE     = 2'd0;
   localparam logic [1:0] WIN_BLACKMAN = 2'd1;
   localparam logic [1:0] WIN_HAMMING  = 2'd2;
   localparam logic [1:0] WIN_UNUSED   = 2'd3;

   localparam logic [15:0] SAMPLE_COUNT_RESET = 16'd1023;

   localparam int BLACK_C0  = 27525;
   localparam int BLACK_C1  = 32768;
   localparam int BLACK_C2  = 5243;
   localparam int HAM_C0    = 35389;
   localparam int HAM_C1    = 30147;
   localparam int WIN_SHIFT = 16;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] TAYLOR_DIV [10] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
                                              64'd132, 64'd182, 64'd240, 64'd306, 64'd380};

   typedef struct packed {
      logic [15:0] sample_count;
      logic [31:0] chirp_rate;
      logic [1:0]  window_mode;
      logic [31:0] window_start;
      logic [31:0] window_step;
   } csr_type;

   typedef struct packed {
      logic [31:0] phase;
      logic [31:0] step;
   } reload_type;

   typedef struct packed {
      logic [31:0] chirp_phase;
      logic [31:0] window_phase;
      logic        last;
      logic        even;
   } front_item_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_LOOK,
      BACK_WIN,
      BACK_MUL,
      BACK_PUT
   } back_state_type;

   // cosine of entry k of a quarter wave, Taylor series in Q2.30
   function automatic longint qcos_value(input int k, input int table_bits,
                                         input int sample_bits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      longint      sum;
      longint      v;
      longint      top;
      int          sh;
      int          j;
      x    = (64'(k) * HALF_PI_Q30) >> (table_bits - 2);
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      sum  = longint'(term);
      for (j = 0; j < 10; j++) begin
         term = (term * x2) >> 30;
         term = term / TAYLOR_DIV[j];
         if ((j & 1) != 0) begin
            sum = sum + longint'(term);
         end else begin
            sum = sum - longint'(term);
         end
      end
      v   = (sum < 0) ? 64'sd0 : sum;
      sh  = 30 - (sample_bits - 1);
      v   = (v + (64'sd1 <<< (sh - 1))) >>> sh;
      top = (64'sd1 <<< (sample_bits - 1)) - 64'sd1;
      return (v > top) ? top : v;
   endfunction

endpackage

// ----- hdl/wlcg_fifo.sv -----
// Small register queue used between front and back and on the result side.
// Depends on wlcg_pkg for the default depth.
`timescale 1ns / 1ps

module wlcg_fifo import wlcg_pkg::*; #(
   parameter int DATA_BITS = 8,
   parameter int DEPTH     = QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] wr_data,
   output logic                 full,
   input  logic                 pop,
   output logic [DATA_BITS-1:0] rd_data,
   output logic                 empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full    = (count_ff == CNT_BITS'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- hdl/wlcg_csr.sv -----
// Configuration registers and the pulse reload values derived from them.
// Depends on wlcg_pkg.
`timescale 1ns / 1ps

module wlcg_csr import wlcg_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   output csr_type     cfg,
   output reload_type  reload,
   output logic        busy
);

   localparam int SETTLE_BITS = $clog2(CSR_SETTLE + 1);

   csr_type                  cfg_ff, cfg_in;
   logic [SETTLE_BITS-1:0]   settle_ff, settle_in;
   logic [31:0]              mm_ff, mm_in;
   logic [31:0]              sprod_ff, sprod_in;
   reload_type               reload_ff, reload_in;
   logic                     write;
   logic [31:0]              count_ext;
   logic [COUNT_BITS-1:0]    n_eff;
   logic [COUNT_BITS-1:0]    n_less;
   logic [COUNT_BITS-2:0]    m;
   logic [63:0]              mm_full;
   logic [63:0]              sprod_full;
   logic [63:0]              pm_full;

   assign csr_ready = 1'b1;
   assign write     = csr_valid & csr_ready;
   assign cfg       = cfg_ff;
   assign reload    = reload_ff;
   assign busy      = (settle_ff != '0);

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         case (csr_index)
            CSR_SAMPLE_COUNT: cfg_in.sample_count = csr_data[15:0];
            CSR_CHIRP_RATE:   cfg_in.chirp_rate   = csr_data;
            CSR_WINDOW_MODE:  cfg_in.window_mode  = csr_data[1:0];
            CSR_WINDOW_START: cfg_in.window_start = csr_data;
            CSR_WINDOW_STEP:  cfg_in.window_step  = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (write) begin
         settle_in = SETTLE_BITS'(CSR_SETTLE);
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - 1'b1;
      end else begin
         settle_in = settle_ff;
      end
   end

   // first sample: phase -rate*M*M, step rate*(2M-1), M = (N-1)/2
   assign count_ext  = 32'(cfg_ff.sample_count);
   assign n_eff      = count_ext[COUNT_BITS-1:0];
   assign n_less     = n_eff - COUNT_BITS'(1);
   assign m          = n_less[COUNT_BITS-1:1];
   assign mm_full    = 64'(m) * 64'(m);
   assign mm_in      = mm_full[31:0];
   assign sprod_full = 64'(cfg_ff.chirp_rate) * 64'({m, 1'b0});
   assign sprod_in   = sprod_full[31:0];
   assign pm_full    = 64'(cfg_ff.chirp_rate) * 64'(mm_ff);

   always_comb begin
      reload_in.phase = 32'd0 - pm_full[31:0];
      reload_in.step  = sprod_ff - cfg_ff.chirp_rate;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_count <= SAMPLE_COUNT_RESET;
         cfg_ff.chirp_rate   <= '0;
         cfg_ff.window_mode  <= '0;
         cfg_ff.window_start <= '0;
         cfg_ff.window_step  <= '0;
         settle_ff           <= SETTLE_BITS'(CSR_SETTLE);
      end else begin
         cfg_ff    <= cfg_in;
         settle_ff <= settle_in;
      end
   end

   always_ff @(posedge clock) begin
      mm_ff     <= mm_in;
      sprod_ff  <= sprod_in;
      reload_ff <= reload_in;
   end

endmodule

// ----- hdl/wlcg_front.sv -----
// Front end: sample counter and second-order phase accumulators, one
// queue entry per accepted beat. Depends on wlcg_pkg.
`timescale 1ns / 1ps

module wlcg_front import wlcg_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic           restart,
   input  csr_type        cfg,
   input  reload_type     reload,
   output front_item_type item
);

   logic [COUNT_BITS-1:0] index_ff, index_in;
   logic [31:0]           phase_ff, phase_in;
   logic [31:0]           step_ff, step_in;
   logic [31:0]           wphase_ff, wphase_in;
   logic [31:0]           count_ext;
   logic [COUNT_BITS-1:0] n_eff;
   logic [COUNT_BITS-1:0] last_idx;
   logic                  start;
   logic [COUNT_BITS-1:0] cur_index;
   logic [31:0]           cur_phase;
   logic [31:0]           cur_step;
   logic [31:0]           cur_wphase;
   logic                  is_last;

   assign count_ext  = 32'(cfg.sample_count);
   assign n_eff      = count_ext[COUNT_BITS-1:0];
   assign last_idx   = n_eff - COUNT_BITS'(1);
   assign start      = restart | (index_ff == '0);
   assign cur_index  = start ? '0 : index_ff;
   assign cur_phase  = start ? reload.phase : phase_ff;
   assign cur_step   = start ? reload.step : step_ff;
   assign cur_wphase = start ? cfg.window_start : wphase_ff;
   assign is_last    = (cur_index == last_idx);

   always_comb begin
      item.chirp_phase  = cur_phase;
      item.window_phase = cur_wphase;
      item.last         = is_last;
      item.even         = ~n_eff[0];
   end

   always_comb begin
      index_in  = index_ff;
      phase_in  = phase_ff;
      step_in   = step_ff;
      wphase_in = wphase_ff;
      if (accept) begin
         index_in  = is_last ? '0 : cur_index + 1'b1;
         phase_in  = cur_phase + cur_step;
         step_in   = cur_step - {cfg.chirp_rate[30:0], 1'b0};
         wphase_in = cur_wphase + cfg.window_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff  <= '0;
         phase_ff  <= '0;
         step_ff   <= '0;
         wphase_ff <= '0;
      end else begin
         index_ff  <= index_in;
         phase_ff  <= phase_in;
         step_ff   <= step_in;
         wphase_ff <= wphase_in;
      end
   end

endmodule

// ----- hdl/wlcg_back.sv -----
// Back end: table lookup, window, multiply and saturate, one entry at a
// time under a small sequencer. Depends on wlcg_pkg.
`timescale 1ns / 1ps

module wlcg_back import wlcg_pkg::*; #(
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
   parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [1:0]               window_mode,
   input  logic                     mid_empty,
   input  front_item_type           mid_item,
   output logic                     mid_pop,
   input  logic                     out_full,
   output logic                     out_push,
   output logic [2*SAMPLE_BITS+1:0] out_data
);

   localparam int STB  = SINE_TABLE_BITS;
   localparam int SB   = SAMPLE_BITS;
   localparam int QTAB = 2 ** (STB - 2);
   localparam int IB   = STB - 1;
   localparam int WB   = SB + 17;
   localparam int PB   = 2 * SB + 1;

   localparam logic [IB-1:0]        QTAB_IDX   = IB'(QTAB);
   localparam logic signed [WB-1:0] UNITY_W    = WB'(2 ** (SB - 1));
   localparam logic signed [WB-1:0] BLACK_BASE = WB'(longint'(BLACK_C0) * (2 ** (SB - 1)));
   localparam logic signed [WB-1:0] HAM_BASE   = WB'(longint'(HAM_C0) * (2 ** (SB - 1)));
   localparam logic signed [WB-1:0] WIN_ROUND  = WB'(2 ** (WIN_SHIFT - 1));
   localparam logic signed [PB-1:0] MUL_ROUND  = PB'(2 ** (SB - 2));
   localparam logic signed [PB-1:0] SAT_HIGH   = PB'(2 ** (SB - 1) - 1);
   localparam logic signed [PB-1:0] SAT_LOW    = -PB'(2 ** (SB - 1));

   back_state_type        state_ff, state_in;
   front_item_type        item_ff, item_in;
   logic signed [SB-1:0]  c_ff, c_in;
   logic signed [SB-1:0]  s_ff, s_in;
   logic signed [SB-1:0]  c1_ff, c1_in;
   logic signed [SB-1:0]  c2_ff, c2_in;
   logic [SB-1:0]         w_ff, w_in;
   logic signed [PB-1:0]  prod_i_ff, prod_i_in;
   logic signed [PB-1:0]  prod_q_ff, prod_q_in;

   logic [SB-2:0]         qtab [QTAB];
   logic [31:0]           lane_phase [4];
   logic                  lane_sine [4];
   logic signed [SB-1:0]  lane_val [4];

   logic signed [WB-1:0]  c1x, c2x, black, ham, wsum, wpos, wrnd;
   logic signed [PB-1:0]  rnd_i, rnd_q, sat_i, sat_q;
   logic signed [SB-1:0]  fin_i, fin_q;
   logic                  win_on;

   for (genvar k = 0; k < QTAB; k++) begin : g_qtab
      assign qtab[k] = (SB - 1)'(qcos_value(k, STB, SB));
   end

   assign lane_phase[0] = item_ff.chirp_phase;
   assign lane_phase[1] = item_ff.chirp_phase;
   assign lane_phase[2] = item_ff.window_phase;
   assign lane_phase[3] = {item_ff.window_phase[30:0], 1'b0};
   assign lane_sine[0]  = 1'b0;
   assign lane_sine[1]  = 1'b1;
   assign lane_sine[2]  = 1'b0;
   assign lane_sine[3]  = 1'b0;

   always_comb begin : lookup
      logic [STB-1:0] idx;
      logic [1:0]     quad;
      logic [IB-1:0]  kk;
      logic [IB-1:0]  jj;
      logic           neg;
      logic [SB-2:0]  mag;
      for (int n = 0; n < 4; n++) begin
         idx  = lane_phase[n][31 -: STB];
         quad = idx[STB-1:STB-2];
         kk   = {1'b0, idx[STB-3:0]};
         jj   = (quad[0] ^ lane_sine[n]) ? QTAB_IDX - kk : kk;
         neg  = lane_sine[n] ? quad[1] : (quad[0] ^ quad[1]);
         mag  = jj[IB-1] ? '0 : qtab[jj[IB-2:0]];
         lane_val[n] = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
   end

   assign c_in  = lane_val[0];
   assign s_in  = lane_val[1];
   assign c1_in = lane_val[2];
   assign c2_in = lane_val[3];

   assign c1x   = WB'(c1_ff);
   assign c2x   = WB'(c2_ff);
   assign black = BLACK_BASE - c1x * WB'(BLACK_C1) + c2x * WB'(BLACK_C2);
   assign ham   = HAM_BASE + c1x * WB'(HAM_C1);
   assign wsum  = (window_mode == WIN_BLACKMAN) ? black : ham;
   assign wpos  = wsum[WB-1] ? '0 : wsum;
   assign wrnd  = (wpos + WIN_ROUND) >>> WIN_SHIFT;
   assign w_in  = (wrnd > UNITY_W) ? SB'(UNITY_W) : SB'(wrnd);

   assign prod_i_in = PB'(c_ff) * PB'($signed({1'b0, w_ff}));
   assign prod_q_in = PB'(s_ff) * PB'($signed({1'b0, w_ff}));

   assign rnd_i  = (prod_i_ff + MUL_ROUND) >>> (SB - 1);
   assign rnd_q  = (prod_q_ff + MUL_ROUND) >>> (SB - 1);
   assign sat_i  = (rnd_i > SAT_HIGH) ? SAT_HIGH : ((rnd_i < SAT_LOW) ? SAT_LOW : rnd_i);
   assign sat_q  = (rnd_q > SAT_HIGH) ? SAT_HIGH : ((rnd_q < SAT_LOW) ? SAT_LOW : rnd_q);
   assign win_on = (window_mode == WIN_BLACKMAN) || (window_mode == WIN_HAMMING);

   always_comb begin
      if (item_ff.even) begin
         fin_i = '0;
         fin_q = '0;
      end else if (win_on) begin
         fin_i = SB'(sat_i);
         fin_q = SB'(sat_q);
      end else begin
         fin_i = c_ff;
         fin_q = s_ff;
      end
   end

   assign out_data = {fin_i, fin_q, item_ff.last, item_ff.even};
   assign item_in  = mid_pop ? mid_item : item_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!mid_empty) state_in = BACK_LOOK;
         end
         BACK_LOOK: state_in = BACK_WIN;
         BACK_WIN:  state_in = BACK_MUL;
         BACK_MUL:  state_in = BACK_PUT;
         BACK_PUT: begin
            if (!out_full) begin
               state_in = mid_empty ? BACK_IDLE : BACK_LOOK;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      mid_pop  = 1'b0;
      out_push = 1'b0;
      case (state_ff)
         BACK_IDLE: mid_pop = ~mid_empty;
         BACK_PUT: begin
            out_push = ~out_full;
            mid_pop  = ~out_full & ~mid_empty;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      c_ff      <= c_in;
      s_ff      <= s_in;
      c1_ff     <= c1_in;
      c2_ff     <= c2_in;
      w_ff      <= w_in;
      prod_i_ff <= prod_i_in;
      prod_q_ff <= prod_q_in;
   end

endmodule

// ----- hdl/windowed_linear_chirp_generator.sv -----
// Top level of the windowed linear chirp generator: register block, front
// end, entry queue, back end and result queue. Depends on wlcg_pkg.
//
//   channel   ports                               beat taken when
//   request   push, full, req_restart             push & !full
//   response  pop, empty, rsp_sample_i/_q,        pop & !empty
//             rsp_last, rsp_length_error
//   csr       csr_valid, csr_ready, csr_index,    csr_valid & csr_ready
//             csr_data
//
// The back-end sequencer works through each sample in four steps (lookup,
// window, multiply, deliver) and takes the next entry only as it delivers the last.
// The front end takes a request beat every cycle while the two-entry queue
// has room and no csr write is settling, so short bursts are absorbed.
// full stays high after reset and after each csr write while the reload
// products settle.
// A full result queue holds the back end in its deliver step.
`timescale 1ns / 1ps

module windowed_linear_chirp_generator import wlcg_pkg::*; #(
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
   parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
   parameter int COUNT_BITS      = COUNT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic                          req_restart,
   output logic                          empty,
   input  logic                          pop,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_i,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_q,
   output logic                          rsp_last,
   output logic                          rsp_length_error,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [2:0]                    csr_index,
   input  logic [31:0]                   csr_data
);

   localparam int ITEM_BITS = $bits(front_item_type);
   localparam int OUT_BITS  = 2 * SAMPLE_BITS + 2;

   csr_type             cfg;
   reload_type          reload;
   logic                csr_busy;
   logic                accept;
   front_item_type      front_item;
   front_item_type      mid_item;
   logic [ITEM_BITS-1:0] mid_rd;
   logic                mid_full;
   logic                mid_empty;
   logic                mid_pop;
   logic                out_full;
   logic                out_push;
   logic [OUT_BITS-1:0] out_wr;
   logic [OUT_BITS-1:0] out_rd;

   assign full     = mid_full | csr_busy;
   assign accept   = push & ~full;
   assign mid_item = front_item_type'(mid_rd);

   wlcg_csr #(
      .COUNT_BITS (COUNT_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .reload    (reload),
      .busy      (csr_busy)
   );

   wlcg_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .restart (req_restart),
      .cfg     (cfg),
      .reload  (reload),
      .item    (front_item)
   );

   wlcg_fifo #(
      .DATA_BITS (ITEM_BITS),
      .DEPTH     (QUEUE_DEPTH)
   ) u_mid_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (accept),
      .wr_data (front_item),
      .full    (mid_full),
      .pop     (mid_pop),
      .rd_data (mid_rd),
      .empty   (mid_empty)
   );

   wlcg_back #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .SAMPLE_BITS     (SAMPLE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .window_mode (cfg.window_mode),
      .mid_empty   (mid_empty),
      .mid_item    (mid_item),
      .mid_pop     (mid_pop),
      .out_full    (out_full),
      .out_push    (out_push),
      .out_data    (out_wr)
   );

   wlcg_fifo #(
      .DATA_BITS (OUT_BITS),
      .DEPTH     (QUEUE_DEPTH)
   ) u_out_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (out_wr),
      .full    (out_full),
      .pop     (pop),
      .rd_data (out_rd),
      .empty   (empty)
   );

   assign rsp_sample_i     = $signed(out_rd[OUT_BITS-1 -: SAMPLE_BITS]);
   assign rsp_sample_q     = $signed(out_rd[SAMPLE_BITS+1 -: SAMPLE_BITS]);
   assign rsp_last         = out_rd[1];
   assign rsp_length_error = out_rd[0];

endmodule
